// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions clocked on clk_i, reset by rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SIB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sib_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted insertion buffer package
// Sizes, opcodes and shared types of the sorted insertion buffer.
// ----------------------------------------------------------------------------
package sib_pkg;

  // Number of entries the buffer can hold.
  localparam int unsigned CAPACITY = 16;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned POS_W = 4;
  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef logic signed [VAL_W-1:0] value_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic   ins;    // Insert the value at its sorted place.
    logic   rot;    // Rotate the occupied part one place toward cell 0.
    value_t value;  // Value being inserted.
  } cell_cmd_t;

endpackage

// ===== rtl/sib_in_if.sv =====
// ----------------------------------------------------------------------------
// Sorted insertion buffer input channel
// Valid/ready channel that carries one command transaction.
// ----------------------------------------------------------------------------
interface sib_in_if import sib_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   opcode;
  value_t value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink (input valid, input opcode, input value, output ready);
endinterface

// ===== rtl/sib_out_if.sv =====
// ----------------------------------------------------------------------------
// Sorted insertion buffer output channel
// Valid/ready channel that carries one result transaction per entry.
// ----------------------------------------------------------------------------
interface sib_out_if import sib_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] position;
  value_t           entry_value;
  logic             entry_valid;
  logic             last;
  logic             overflow;

  modport source (
    output valid, output position, output entry_value, output entry_valid,
    output last, output overflow, input ready
  );
  modport sink (
    input valid, input position, input entry_value, input entry_valid,
    input last, input overflow, output ready
  );
endinterface

// ===== rtl/sorted_insertion_buffer.sv =====
// ----------------------------------------------------------------------------
// Sorted insertion buffer
// Keeps signed values in ascending order and streams the contents out.
// ----------------------------------------------------------------------------
// The block takes command transactions on in_i and returns result
// transactions on out_o, both valid/ready channels. An insert places the
// value after every stored entry that is not greater than it, in the same
// cycle it is accepted, and then the whole sorted contents are sent, one
// transaction per entry, with last set on the final one. A clear empties the
// store and sends a single transaction with entry_valid low. An insert into
// a full store is dropped and the unchanged contents go out with overflow set.
// After acceptance the sequencer enters its emit state, which loads the
// first result into the result register. The readout rotates the chain one
// place per cycle and the input waits until the last result has been
// registered, so no new command is taken while a readout is in flight.
// A stall on out_o holds the result register and freezes the rotation.
// Reset empties the store; the cell contents themselves are not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_insertion_buffer import sib_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  sib_in_if.sink   in_i,
  sib_out_if.source out_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic             state_q;
  logic [CNT_W-1:0] cnt_q;
  logic [IDX_W-1:0] idx_q;
  logic             clr_q;
  logic             ovf_q;

  logic             out_valid_q;
  logic [POS_W-1:0] out_pos_q;
  value_t           out_val_q;
  logic             out_ev_q;
  logic             out_last_q;
  logic             out_ovf_q;

  logic      in_acc;
  logic      is_clr;
  logic      full;
  logic      out_free;
  logic      emit_step;
  logic      emit_last;
  cell_cmd_t cmd;

  value_t              cell_val [CAPACITY];
  logic [CAPACITY-1:0] cell_gt;

  // Commands are only taken while no readout is in flight.
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign is_clr     = (in_i.opcode == OP_CLEAR);
  assign full       = (cnt_q == CNT_W'(CAPACITY));

  // The result register may be reloaded when empty or being drained.
  assign out_free  = !out_valid_q || out_o.ready;
  assign emit_step = (state_q == ST_EMIT) && out_free;
  assign emit_last = clr_q || (idx_q == IDX_W'(cnt_q - CNT_W'(1)));

  assign cmd.ins   = in_acc && !is_clr && !full;
  assign cmd.rot   = emit_step && !clr_q;
  assign cmd.value = in_i.value;

  // The chain of cells. Each cell sees its lower neighbor for the insert
  // shift and its upper neighbor for the readout rotation. The top occupied
  // cell wraps around to cell 0, so after one full readout every entry is
  // back in its place.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   occ;
    logic   tail;
    logic   wrap;
    value_t prev_val;
    logic   prev_gt;
    value_t next_val;
    value_t rot_val;

    assign occ  = (CNT_W'(i) < cnt_q);
    assign tail = (cnt_q == CNT_W'(i));
    assign wrap = (cnt_q == CNT_W'(i + 1));

    if (i == 0) begin : g_first
      assign prev_val = cell_val[0];
      assign prev_gt  = 1'b0;
    end else begin : g_inner
      assign prev_val = cell_val[i-1];
      assign prev_gt  = cell_gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_top
      assign next_val = cell_val[0];
    end else begin : g_below
      assign next_val = cell_val[i+1];
    end

    assign rot_val = wrap ? cell_val[0] : next_val;

    sib_cell u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .occ_i      (occ),
      .tail_i     (tail),
      .prev_val_i (prev_val),
      .prev_gt_i  (prev_gt),
      .rot_val_i  (rot_val),
      .val_o      (cell_val[i]),
      .gt_o       (cell_gt[i])
    );
  end

  // Control: fill count, readout index and the two-state sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      clr_q   <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= ST_EMIT;
            idx_q   <= '0;
            clr_q   <= is_clr;
            ovf_q   <= !is_clr && full;
            if (is_clr) begin
              cnt_q <= '0;
            end else if (!full) begin
              cnt_q <= cnt_q + CNT_W'(1);
            end
          end
        end
        ST_EMIT: begin
          if (emit_step) begin
            if (emit_last) begin
              state_q <= ST_IDLE;
            end else begin
              idx_q <= idx_q + IDX_W'(1);
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_step) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload; cell 0 always holds the entry due next.
  always_ff @(posedge clk_i) begin
    if (emit_step) begin
      if (clr_q) begin
        out_pos_q  <= '0;
        out_val_q  <= '0;
        out_ev_q   <= 1'b0;
        out_last_q <= 1'b1;
        out_ovf_q  <= 1'b0;
      end else begin
        out_pos_q  <= POS_W'(idx_q);
        out_val_q  <= cell_val[0];
        out_ev_q   <= 1'b1;
        out_last_q <= emit_last;
        out_ovf_q  <= ovf_q;
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.position    = out_pos_q;
  assign out_o.entry_value = out_val_q;
  assign out_o.entry_valid = out_ev_q;
  assign out_o.last        = out_last_q;
  assign out_o.overflow    = out_ovf_q;

  // The fill count never runs past the capacity.
  `SIB_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(CAPACITY), "entry count above capacity")

  // An insert into a store that is not full grows it by exactly one entry.
  `SIB_ASSERT_NEXT(a_cnt_grow, in_acc && !is_clr && !full, cnt_q == $past(cnt_q) + CNT_W'(1), "insert did not add one entry")

  // A readout of contents always has at least one entry to send.
  `SIB_ASSERT_IMPL(a_emit_nonempty, (state_q == ST_EMIT) && !clr_q, cnt_q != '0, "readout of an empty store")

  // A clear leaves the store empty on the following cycle.
  `SIB_ASSERT_NEXT(a_clear_empty, in_acc && is_clr, cnt_q == '0, "clear left entries behind")

endmodule

// ===== rtl/sib_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted insertion buffer cell
// One storage slot of the sorted chain with its compare and shift logic.
// ----------------------------------------------------------------------------
module sib_cell import sib_pkg::*; (
  input  logic      clk_i,
  input  cell_cmd_t cmd_i,
  input  logic      occ_i,       // This slot holds a valid entry.
  input  logic      tail_i,      // This slot is the first free one.
  input  value_t    prev_val_i,
  input  logic      prev_gt_i,
  input  value_t    rot_val_i,
  output value_t    val_o,
  output logic      gt_o
);

  value_t val_q, val_d;

  // Entries are ascending, so the cells that hold a greater value form a
  // contiguous run at the top of the occupied part.
  assign gt_o = occ_i && (val_q > cmd_i.value);

  always_comb begin
    val_d = val_q;
    if (cmd_i.ins) begin
      if (prev_gt_i) begin
        val_d = prev_val_i;
      end else if (gt_o || tail_i) begin
        val_d = cmd_i.value;
      end
    end else if (cmd_i.rot && occ_i) begin
      val_d = rot_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// Sorted insertion buffer testbench
// Sends insert and clear commands and checks every streamed readout entry.
// ----------------------------------------------------------------------------
// A shadow copy of the sorted store is updated for each accepted command. It
// yields the readout that the block must stream back: one entry per stored
// value, or a single empty entry after a clear. Every result transaction is
// compared field by field with the oldest expected entry. A directed pass
// covers the value extremes, equal values, a full store and clears. Random
// phases then vary the sender gaps and the receiver stalls. One phase lets
// the readout drain completely after each burst of commands.
// ----------------------------------------------------------------------------
module tb;
  import sib_pkg::*;

  localparam value_t VALUE_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam value_t VALUE_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam int unsigned MAX_REPORTS = 10;

  // One readout entry as the block should stream it.
  typedef struct {
    logic [POS_W-1:0] position;
    value_t           entry_value;
    logic             entry_valid;
    logic             last;
    logic             overflow;
  } readout_t;

  logic clk_i;
  logic rst_ni;

  sib_in_if  cmd_bus ();
  sib_out_if readout_bus ();

  sorted_insertion_buffer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_bus),
    .out_o  (readout_bus)
  );

  // Shadow of the block's store, kept in ascending order.
  value_t      shadow_entries [CAPACITY];
  int unsigned shadow_count;

  // Readout entries that have been predicted but not yet received.
  readout_t readout_q [$];

  int unsigned mismatch_count;

  // Percent of cycles in which the sender holds back or the receiver stalls.
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Fixed upper bound on the run. The slowest legal run stays far below it.
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // Applies one accepted command to the shadow store and queues the
  // readout that it causes.
  function automatic void predict_readout(logic opcode, value_t value);
    readout_t entry;
    int       slot;
    logic     dropped;
    if (opcode == OP_CLEAR) begin
      shadow_count = 0;
      entry.position    = '0;
      entry.entry_value = '0;
      entry.entry_valid = 1'b0;
      entry.last        = 1'b1;
      entry.overflow    = 1'b0;
      readout_q.push_back(entry);
      return;
    end
    dropped = (shadow_count >= CAPACITY);
    if (!dropped) begin
      // Walk down from the top and shift every strictly larger entry up, so
      // that a new value lands after all entries equal to it.
      slot = shadow_count;
      while (slot > 0 && shadow_entries[slot-1] > value) begin
        shadow_entries[slot] = shadow_entries[slot-1];
        slot--;
      end
      shadow_entries[slot] = value;
      shadow_count++;
    end
    for (int k = 0; k < shadow_count; k++) begin
      entry.position    = k[POS_W-1:0];
      entry.entry_value = shadow_entries[k];
      entry.entry_valid = 1'b1;
      entry.last        = (k + 1 == shadow_count);
      entry.overflow    = dropped;
      readout_q.push_back(entry);
    end
  endfunction

  // Everything is sampled at the rising edge. The testbench drives its side
  // at the falling edge, and the block updates its registers after the edge,
  // so the values seen here are the ones that the handshake used.
  always @(posedge clk_i) begin : readout_monitor
    readout_t got;
    readout_t want;
    if (rst_ni) begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        predict_readout(cmd_bus.opcode, cmd_bus.value);
      end
      if (readout_bus.valid && readout_bus.ready) begin
        got.position    = readout_bus.position;
        got.entry_value = readout_bus.entry_value;
        got.entry_valid = readout_bus.entry_valid;
        got.last        = readout_bus.last;
        got.overflow    = readout_bus.overflow;
        if (readout_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("Unexpected readout: pos=%0d val=%0d valid=%b last=%b ovf=%b",
                     got.position, got.entry_value, got.entry_valid, got.last,
                     got.overflow);
          end
        end else begin
          want = readout_q.pop_front();
          if (got.position !== want.position || got.entry_value !== want.entry_value ||
              got.entry_valid !== want.entry_valid || got.last !== want.last ||
              got.overflow !== want.overflow) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("Readout mismatch: expected pos=%0d val=%0d valid=%b last=%b ovf=%b",
                       want.position, want.entry_value, want.entry_valid, want.last,
                       want.overflow);
              $display("                  actual   pos=%0d val=%0d valid=%b last=%b ovf=%b",
                       got.position, got.entry_value, got.entry_valid, got.last,
                       got.overflow);
            end
          end
        end
      end
    end
  end

  // The receiver decides at every falling edge whether to stall next cycle.
  always @(negedge clk_i) begin
    readout_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Sends one command transaction. Valid stays high from one transaction to
  // the next unless the sender decides to idle first.
  task automatic send_command(logic opcode, value_t value);
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd_bus.valid  <= 1'b1;
    cmd_bus.opcode <= opcode;
    cmd_bus.value  <= value;
    @(posedge clk_i);
    while (!cmd_bus.ready) @(posedge clk_i);
  endtask

  // Small values give many equal entries, the extremes test the signed
  // compare, and the rest toggles every bit.
  function automatic value_t random_value();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 25) begin
      return value_t'(int'($urandom_range(8)) - 4);
    end else if (pick < 35) begin
      case ($urandom_range(3))
        0:       return VALUE_MIN;
        1:       return VALUE_MAX;
        2:       return '0;
        default: return '1;
      endcase
    end
    return value_t'($urandom);
  endfunction

  // Mostly inserts, so that the store fills up and overflows now and then.
  task automatic send_random_commands(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 5) begin
        send_command(OP_CLEAR, random_value());
      end else begin
        send_command(OP_INSERT, random_value());
      end
    end
  endtask

  task automatic wait_readout_drained();
    while (readout_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_idling(int unsigned sender_pct, int unsigned receiver_pct);
    sender_idle_pct    = sender_pct;
    receiver_stall_pct = receiver_pct;
  endtask

  task automatic test_directed_cases();
    set_idling(0, 0);
    // A clear on an empty store still returns one empty entry; its value
    // field must be ignored.
    send_command(OP_CLEAR, VALUE_MAX);
    // Extremes in mixed order, then equal values at the bottom, middle and top.
    send_command(OP_INSERT, '0);
    send_command(OP_INSERT, VALUE_MAX);
    send_command(OP_INSERT, VALUE_MIN);
    send_command(OP_INSERT, '1);
    send_command(OP_INSERT, value_t'(1));
    send_command(OP_INSERT, '0);
    send_command(OP_INSERT, VALUE_MAX);
    send_command(OP_INSERT, VALUE_MIN);
    // Falling values each land below the top entries and shift them up.
    for (int i = 8; i < CAPACITY; i++) begin
      send_command(OP_INSERT, value_t'(1000 - i));
    end
    // The store is full now: both inserts are dropped and flagged.
    send_command(OP_INSERT, value_t'(5));
    send_command(OP_INSERT, VALUE_MIN);
    send_command(OP_CLEAR, '0);
    send_command(OP_INSERT, value_t'(42));
  endtask

  task automatic test_streaming();
    set_idling(0, 0);
    send_random_commands(100);
  endtask

  task automatic test_sender_gaps();
    set_idling(85, 0);
    send_random_commands(90);
  endtask

  task automatic test_receiver_stalls();
    set_idling(0, 85);
    send_random_commands(90);
  endtask

  task automatic test_mixed_idling();
    set_idling(12, 12);
    send_random_commands(90);
  endtask

  // The sender stops until the whole readout has come back, so the block
  // also starts commands from a fully idle state in the middle of a run.
  task automatic test_pause_until_drained();
    set_idling(12, 12);
    for (int burst = 0; burst < 4; burst++) begin
      send_random_commands(12);
      // Drop valid so that the last command is not offered a second time.
      @(negedge clk_i);
      cmd_bus.valid <= 1'b0;
      wait_readout_drained();
    end
  endtask

  initial begin
    rst_ni             = 1'b0;
    cmd_bus.valid      = 1'b0;
    cmd_bus.opcode     = OP_INSERT;
    cmd_bus.value      = '0;
    readout_bus.ready  = 1'b0;
    shadow_count       = 0;
    mismatch_count     = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_cases();
    test_streaming();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_idling();
    test_pause_until_drained();

    @(negedge clk_i);
    cmd_bus.valid <= 1'b0;
    wait_readout_drained();
    // Give a stray extra result the chance to show up.
    repeat (2 * CAPACITY + 4) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sib_pkg.sv
rtl/sib_in_if.sv
rtl/sib_out_if.sv
rtl/sib_cell.sv
rtl/sorted_insertion_buffer.sv
verif/tb.sv
